>>> rtl/xpm_colour_table_decoder_top_macros.svh
// assertion macros shared by the colour table decoder modules
`ifndef XPM_COLOUR_TABLE_DECODER_TOP_MACROS_SVH
`define XPM_COLOUR_TABLE_DECODER_TOP_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define XPMCT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define XPMCT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/xpmct_pkg.sv
// shared types and constants of the colour table decoder
`default_nettype none

package xpmct_pkg;

    localparam int ID_CHARS   = 5;
    localparam int CHAR_W     = 8;
    localparam int ID_W       = ID_CHARS * CHAR_W;
    localparam int COLOUR_W   = 32;
    localparam int LEN_W      = 3;
    localparam int CFG_W      = 9;
    localparam int CPC_W      = 3;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 48;

    localparam logic [LEN_W-1:0] CPC_RESET = 3'd1;
    localparam logic [CFG_W-1:0] CC_RESET  = 9'd2;

    // field phases of a colour line
    localparam logic [2:0] PH_ID   = 3'd0;
    localparam logic [2:0] PH_HASH = 3'd2;
    localparam logic [2:0] PH_HEX  = 3'd3;
    localparam logic [2:0] PH_LAST = 3'd7;

    localparam logic [3:0] HEX_FULL = 4'd8;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_HASH  = 8'h23;

    typedef enum logic [0:0] {
        REG_CHARS_PER_COLOUR = 1'b0,
        REG_COLOUR_COUNT     = 1'b1
    } cfg_reg_t;

    localparam logic OP_CHAR     = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;
    localparam logic KIND_ENTRY  = 1'b0;
    localparam logic KIND_LOOKUP = 1'b1;

    typedef struct packed {
        logic                valid;
        logic                found;
        logic                error;
        logic [7:0]          index;
        logic [COLOUR_W-1:0] colour;
    } res_t;

    // id length clamped to 1 .. ID_CHARS
    function automatic logic [LEN_W-1:0] id_len(input logic [CPC_W-1:0] cpc);
        logic [LEN_W-1:0] n;
        n = cpc;
        if (n == '0) begin
            n = LEN_W'(1);
        end else if (n > LEN_W'(ID_CHARS)) begin
            n = LEN_W'(ID_CHARS);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

>>> rtl/xpm_colour_table_decoder_top.sv
// colour character item: the result of a line end is in the output register next cycle
// pixel lookup: entries 0 .. n-1 are read in order and the first match wins; a miss reports found 0
// n is min(colour_count, MAX_COLOURS); entries are compared one a cycle through the table read port
// no item is taken while a lookup runs or while the output register is full and not being read
// aresetn is synchronous, active low: clears parser, sequencer, handshake and config registers
// the colour and id table is not cleared; lookups compare entries 0 .. n-1 whether or not written since reset
`default_nettype none

module xpm_colour_table_decoder_top #(
    parameter int MAX_COLOURS = 256
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // config write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [0:0]                       cfg_index,
    input  wire logic [xpmct_pkg::CFG_W-1:0]      cfg_wdata,
    // input words
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [xpmct_pkg::S_TDATA_W-1:0]  s_tdata,  // ch[7:0], pixel_id[47:8]
    input  wire logic [0:0]                       s_tuser,  // op[0]
    input  wire logic                             s_tlast,
    // result words
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [xpmct_pkg::M_TDATA_W-1:0]       m_tdata,  // colour_index[7:0],
                                                            // colour_value[39:8], found[40],
                                                            // error[41], zero[47:42]
    output logic [0:0]                            m_tuser   // kind[0]
);

    localparam int CNT_W = $clog2(MAX_COLOURS + 1);
    localparam int IDX_W = $clog2(MAX_COLOURS);
    localparam int CMP_W = (CNT_W > xpmct_pkg::CFG_W) ? CNT_W : xpmct_pkg::CFG_W;
    localparam int RAM_W = xpmct_pkg::ID_W + xpmct_pkg::COLOUR_W;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t                          state_reg, state_next;
    logic                            m_tvalid_reg, m_tvalid_next;
    logic                            kind_reg, kind_next;
    xpmct_pkg::res_t                 out_reg, out_next;
    logic [xpmct_pkg::CPC_W-1:0]     cpc_reg;
    logic [xpmct_pkg::CFG_W-1:0]     cc_reg;

    logic                            out_free;
    logic                            accept;
    logic                            char_take;
    logic                            lookup_start;
    logic                            scan_ack;
    logic [xpmct_pkg::LEN_W-1:0]     len;
    logic [CMP_W-1:0]                cc_ext;
    logic [CNT_W-1:0]                n_use;

    logic                            wr_en;
    logic [IDX_W-1:0]                wr_addr;
    logic [RAM_W-1:0]                wr_data;
    logic                            rd_en;
    logic [IDX_W-1:0]                rd_addr;
    logic [RAM_W-1:0]                rd_data;
    xpmct_pkg::res_t                 line_res;
    xpmct_pkg::res_t                 scan_res;

    assign len    = xpmct_pkg::id_len(cpc_reg);
    assign cc_ext = CMP_W'(cc_reg);
    assign n_use  = (cc_ext > CMP_W'(MAX_COLOURS)) ? CNT_W'(MAX_COLOURS) : CNT_W'(cc_ext);

    assign out_free     = !m_tvalid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE) && out_free;
    assign accept       = s_tvalid && s_tready;
    assign char_take    = accept && (s_tuser[0] == xpmct_pkg::OP_CHAR);
    assign lookup_start = accept && (s_tuser[0] == xpmct_pkg::OP_LOOKUP);
    assign scan_ack     = (state_reg == ST_LOOKUP) && scan_res.valid && out_free;

    xpmct_parse #(
        .MAX_COLOURS (MAX_COLOURS)
    ) u_parse (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (char_take),
        .ch       (s_tdata[7:0]),
        .line_end (s_tlast),
        .id_len   (len),
        .n_use    (n_use),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .res      (line_res)
    );

    xpmct_scan #(
        .MAX_COLOURS (MAX_COLOURS)
    ) u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (lookup_start),
        .pixel_id (s_tdata[47:8]),
        .id_len   (len),
        .n_use    (n_use),
        .ack      (scan_ack),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .res      (scan_res)
    );

    xpmct_ram #(
        .WIDTH (RAM_W),
        .DEPTH (MAX_COLOURS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        kind_next     = kind_reg;
        out_next      = out_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (line_res.valid) begin
                    m_tvalid_next = 1'b1;
                    kind_next     = xpmct_pkg::KIND_ENTRY;
                    out_next      = line_res;
                end
                if (lookup_start) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (scan_ack) begin
                    m_tvalid_next = 1'b1;
                    kind_next     = xpmct_pkg::KIND_LOOKUP;
                    out_next      = scan_res;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            cpc_reg      <= xpmct_pkg::CPC_RESET;
            cc_reg       <= xpmct_pkg::CC_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en) begin
                unique case (xpmct_pkg::cfg_reg_t'(cfg_index))
                    xpmct_pkg::REG_CHARS_PER_COLOUR: cpc_reg <= cfg_wdata[xpmct_pkg::CPC_W-1:0];
                    xpmct_pkg::REG_COLOUR_COUNT:     cc_reg  <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
        kind_reg <= kind_next;
        out_reg  <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {6'd0, out_reg.error, out_reg.found, out_reg.colour, out_reg.index};

`include "xpm_colour_table_decoder_top_macros.svh"

    `XPMCT_ASSERT_NEXT(a_lookup_blocks, lookup_start, !s_tready, "input taken during a lookup")

endmodule

`default_nettype wire

>>> rtl/xpmct_ram.sv
// generic single write port ram with registered read
`default_nettype none

module xpmct_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/xpmct_parse.sv
// colour line parser: id capture, hex accumulation and table writes
`default_nettype none

module xpmct_parse #(
    parameter int MAX_COLOURS = 256,
    localparam int CNT_W = $clog2(MAX_COLOURS + 1),
    localparam int IDX_W = $clog2(MAX_COLOURS)
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     take,
    input  wire logic [7:0]               ch,
    input  wire logic                     line_end,
    input  wire logic [xpmct_pkg::LEN_W-1:0] id_len,
    input  wire logic [CNT_W-1:0]         n_use,
    output logic                          wr_en,
    output logic [IDX_W-1:0]              wr_addr,
    output logic [xpmct_pkg::ID_W+xpmct_pkg::COLOUR_W-1:0] wr_data,
    output xpmct_pkg::res_t               res
);

    localparam int EXT_W = (IDX_W > 8) ? IDX_W : 8;

    logic [2:0]                        phase_reg, phase_next;
    logic [2:0]                        idcnt_reg, idcnt_next;
    logic [xpmct_pkg::ID_W-1:0]        idcap_reg, idcap_next;
    logic [xpmct_pkg::COLOUR_W-1:0]    hex_reg, hex_next;
    logic [3:0]                        hexcnt_reg, hexcnt_next;
    logic [CNT_W-1:0]                  entry_reg, entry_next;
    logic                              sticky_reg, sticky_next;

    logic                              is_ws;
    logic                              hex_ok;
    logic [3:0]                        hex_val;
    logic                              full;
    logic                              store;
    logic [4:0]                        align_sh;
    logic [xpmct_pkg::COLOUR_W-1:0]    colour;
    logic [xpmct_pkg::ID_W-1:0]        id_line;
    logic [EXT_W-1:0]                  idx_ext;

    assign is_ws = (ch == xpmct_pkg::CH_SPACE) || (ch == xpmct_pkg::CH_TAB) ||
                   (ch == xpmct_pkg::CH_LF)    || (ch == xpmct_pkg::CH_CR);

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            hex_val = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            hex_val = 4'(ch - 8'h57);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            hex_val = 4'(ch - 8'h37);
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        phase_next  = phase_reg;
        idcnt_next  = idcnt_reg;
        idcap_next  = idcap_reg;
        hex_next    = hex_reg;
        hexcnt_next = hexcnt_reg;
        entry_next  = entry_reg;
        sticky_next = sticky_reg;
        full        = 1'b0;
        store       = 1'b0;
        align_sh    = '0;
        colour      = '0;
        id_line     = '0;
        idx_ext     = EXT_W'(entry_reg[IDX_W-1:0]);
        wr_en       = 1'b0;
        wr_addr     = entry_reg[IDX_W-1:0];
        res         = '0;

        if (take) begin
            if (is_ws) begin
                if (idcnt_reg != 3'd0 && phase_reg != xpmct_pkg::PH_LAST) begin
                    phase_next = phase_reg + 3'd1;
                end
            end else begin
                unique case (phase_reg)
                    xpmct_pkg::PH_ID: begin
                        if (idcnt_reg < id_len) begin
                            for (int i = 0; i < xpmct_pkg::ID_CHARS; i++) begin
                                if (idcnt_reg == 3'(i)) begin
                                    idcap_next[i*8 +: 8] = ch;
                                end
                            end
                            idcnt_next = idcnt_reg + 3'd1;
                        end
                    end
                    xpmct_pkg::PH_HASH: begin
                        if (ch == xpmct_pkg::CH_HASH) begin
                            phase_next = xpmct_pkg::PH_HEX;
                        end
                    end
                    xpmct_pkg::PH_HEX: begin
                        if (hex_ok) begin
                            hex_next = {hex_reg[xpmct_pkg::COLOUR_W-5:0], hex_val};
                            if (hexcnt_reg < xpmct_pkg::HEX_FULL) begin
                                hexcnt_next = hexcnt_reg + 4'd1;
                            end
                        end else begin
                            sticky_next = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end

            if (line_end) begin
                full     = (entry_reg >= n_use);
                store    = !sticky_next && !full;
                // left-align short colours
                align_sh = {3'(xpmct_pkg::HEX_FULL - hexcnt_next), 2'b00};
                if (hexcnt_next == 4'd0) begin
                    colour = '0;
                end else if (hexcnt_next >= xpmct_pkg::HEX_FULL) begin
                    colour = hex_next;
                end else begin
                    colour = hex_next << align_sh;
                end
                // id including this word, before the line state is cleared
                id_line = idcap_next;

                wr_en      = store;
                res.valid  = 1'b1;
                res.found  = store;
                res.error  = !store;
                res.index  = store ? idx_ext[7:0] : 8'd0;
                res.colour = store ? colour : '0;
                if (store) begin
                    entry_next = entry_reg + CNT_W'(1);
                end

                phase_next  = xpmct_pkg::PH_ID;
                idcnt_next  = 3'd0;
                idcap_next  = '0;
                hex_next    = '0;
                hexcnt_next = 4'd0;
            end
        end
    end

    assign wr_data = {colour, id_line};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= xpmct_pkg::PH_ID;
            idcnt_reg  <= 3'd0;
            idcap_reg  <= '0;
            hex_reg    <= '0;
            hexcnt_reg <= 4'd0;
            entry_reg  <= '0;
            sticky_reg <= 1'b0;
        end else begin
            phase_reg  <= phase_next;
            idcnt_reg  <= idcnt_next;
            idcap_reg  <= idcap_next;
            hex_reg    <= hex_next;
            hexcnt_reg <= hexcnt_next;
            entry_reg  <= entry_next;
            sticky_reg <= sticky_next;
        end
    end

`include "xpm_colour_table_decoder_top_macros.svh"

    `XPMCT_ASSERT_SAME(a_hexcnt_sat, 1'b1, hexcnt_reg <= xpmct_pkg::HEX_FULL, "hex count past 8")
    `XPMCT_ASSERT_NEXT(a_line_clear, take && line_end, (phase_reg == xpmct_pkg::PH_ID) && (idcnt_reg == 3'd0) && (hexcnt_reg == 4'd0), "line state not cleared")

endmodule

`default_nettype wire

>>> rtl/xpmct_scan.sv
// lookup sequencer: walks the table one entry a cycle through a shared comparator
`default_nettype none

module xpmct_scan #(
    parameter int MAX_COLOURS = 256,
    localparam int CNT_W = $clog2(MAX_COLOURS + 1),
    localparam int IDX_W = $clog2(MAX_COLOURS)
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [xpmct_pkg::ID_W-1:0]  pixel_id,
    input  wire logic [xpmct_pkg::LEN_W-1:0] id_len,
    input  wire logic [CNT_W-1:0]            n_use,
    input  wire logic                        ack,
    output logic                             rd_en,
    output logic [IDX_W-1:0]                 rd_addr,
    input  wire logic [xpmct_pkg::ID_W+xpmct_pkg::COLOUR_W-1:0] rd_data,
    output xpmct_pkg::res_t                  res
);

    localparam int EXT_W = (IDX_W > 8) ? IDX_W : 8;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } scan_state_t;

    scan_state_t                      st_reg, st_next;
    logic [CNT_W-1:0]                 rd_idx_reg, rd_idx_next;
    logic                             cmp_valid_reg, cmp_valid_next;
    logic [IDX_W-1:0]                 cmp_idx_reg, cmp_idx_next;
    logic [xpmct_pkg::ID_W-1:0]       want_reg, want_next;
    logic [xpmct_pkg::ID_W-1:0]       mask_reg, mask_next;
    logic [CNT_W-1:0]                 n_reg, n_next;
    logic                             hit_reg, hit_next;
    logic [7:0]                       idx_reg, idx_next;
    logic [xpmct_pkg::COLOUR_W-1:0]   colour_reg, colour_next;

    logic [xpmct_pkg::ID_W-1:0]       mask_in;
    logic                             match_now;
    logic [EXT_W-1:0]                 idx_ext;

    always_comb begin
        for (int i = 0; i < xpmct_pkg::ID_CHARS; i++) begin
            mask_in[i*8 +: 8] = (i < int'(id_len)) ? 8'hFF : 8'h00;
        end
    end

    // entry read last cycle is compared now
    assign match_now = cmp_valid_reg &&
                       ((rd_data[xpmct_pkg::ID_W-1:0] & mask_reg) == want_reg);
    assign idx_ext   = EXT_W'(cmp_idx_reg);
    assign rd_en     = (st_reg == S_RUN) && (rd_idx_reg < n_reg) && !match_now;
    assign rd_addr   = rd_idx_reg[IDX_W-1:0];

    always_comb begin
        st_next        = st_reg;
        rd_idx_next    = rd_idx_reg;
        cmp_valid_next = 1'b0;
        cmp_idx_next   = cmp_idx_reg;
        want_next      = want_reg;
        mask_next      = mask_reg;
        n_next         = n_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        colour_next    = colour_reg;

        unique case (st_reg)
            S_IDLE: begin
                if (start) begin
                    st_next     = S_RUN;
                    rd_idx_next = '0;
                    want_next   = pixel_id & mask_in;
                    mask_next   = mask_in;
                    n_next      = n_use;
                end
            end
            S_RUN: begin
                if (match_now) begin
                    st_next     = S_DONE;
                    hit_next    = 1'b1;
                    idx_next    = idx_ext[7:0];
                    colour_next = rd_data[xpmct_pkg::ID_W +: xpmct_pkg::COLOUR_W];
                end else if (rd_en) begin
                    rd_idx_next    = rd_idx_reg + CNT_W'(1);
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = rd_idx_reg[IDX_W-1:0];
                end else if (!cmp_valid_reg) begin
                    st_next     = S_DONE;
                    hit_next    = 1'b0;
                    idx_next    = 8'd0;
                    colour_next = '0;
                end
            end
            S_DONE: begin
                if (ack) begin
                    st_next = S_IDLE;
                end
            end
            default: begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        res        = '0;
        res.valid  = (st_reg == S_DONE);
        res.found  = hit_reg;
        res.index  = idx_reg;
        res.colour = colour_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= S_IDLE;
            cmp_valid_reg <= 1'b0;
            rd_idx_reg    <= '0;
        end else begin
            st_reg        <= st_next;
            cmp_valid_reg <= cmp_valid_next;
            rd_idx_reg    <= rd_idx_next;
        end
        cmp_idx_reg <= cmp_idx_next;
        want_reg    <= want_next;
        mask_reg    <= mask_next;
        n_reg       <= n_next;
        hit_reg     <= hit_next;
        idx_reg     <= idx_next;
        colour_reg  <= colour_next;
    end

`include "xpm_colour_table_decoder_top_macros.svh"

    `XPMCT_ASSERT_SAME(a_cmp_in_range, cmp_valid_reg, CNT_W'(cmp_idx_reg) < n_reg, "compared entry beyond table in use")
    `XPMCT_ASSERT_NEXT(a_done_holds, (st_reg == S_DONE) && !ack, (st_reg == S_DONE) && $stable(res), "lookup result changed before taken")

endmodule

`default_nettype wire

>>> dv/tb_xpm_colour_table_decoder_top.sv
// self-checking testbench for the xpm colour table decoder: colour lines, pixel lookups, config
`timescale 1ns / 100ps

module tb_xpm_colour_table_decoder_top;

    import xpmct_pkg::*;

    localparam int MAX_PENS    = 256;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 16;
    localparam logic [4:0] NOT_HEX = 5'b10000;

    typedef struct packed {
        logic            op;
        logic [7:0]      ch;
        logic            line_end;
        logic [ID_W-1:0] pixel_id;
    } xpm_word_t;

    typedef struct packed {
        logic                kind;
        logic [7:0]          index;
        logic [COLOUR_W-1:0] colour;
        logic                found;
        logic                error;
    } pen_reply_t;

    logic                 aclk;
    logic                 aresetn   = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [0:0]           cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic [0:0]           s_tuser   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [0:0]           m_tuser;

    xpm_colour_table_decoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // words waiting for the driver and replies the block still owes
    xpm_word_t  word_q[$];
    pen_reply_t reply_q[$];
    int         words_queued = 0;
    int         words_taken  = 0;
    int         fail_count   = 0;
    int         quiet_cycles = 0;
    logic       s_took = 1'b0;
    logic       m_took = 1'b0;
    int         s_gap  = 0;
    int         m_wait = 0;
    bit         s_burst = 1'b0;
    bit         m_burst = 1'b0;

    // shadow of the decoder state
    logic [CPC_W-1:0]    reg_cpc = CPC_RESET;
    logic [CFG_W-1:0]    reg_cc  = CC_RESET;
    logic [2:0]          line_phase = PH_ID;
    int                  id_got = 0;
    logic [ID_W-1:0]     id_word = '0;
    logic [COLOUR_W-1:0] hex_sum = '0;
    logic [3:0]          hex_digits = '0;
    int                  pen_next = 0;
    logic                bad_hex_seen = 1'b0;
    logic [ID_W-1:0]     pen_ids[MAX_PENS];
    logic [COLOUR_W-1:0] pen_colours[MAX_PENS];

    function automatic int id_chars_now();
        int n;
        n = reg_cpc;
        if (n == 0) n = 1;
        if (n > ID_CHARS) n = ID_CHARS;
        return n;
    endfunction

    function automatic int pens_in_use();
        return (reg_cc > MAX_PENS) ? MAX_PENS : int'(reg_cc);
    endfunction

    function automatic logic [ID_W-1:0] id_mask_now();
        logic [ID_W-1:0] m;
        m = '0;
        for (int i = 0; i < id_chars_now(); i++) m[i*8 +: 8] = 8'hFF;
        return m;
    endfunction

    function automatic bit is_space(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    function automatic logic [4:0] hex_nibble(input logic [7:0] c);
        if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
        if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
        if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
        return NOT_HEX;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] v;
        v = {$urandom, $urandom};
        return v[ID_W-1:0];
    endfunction

    function automatic int draw_wait(input bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    // one word through the decoder: updates the shadow state, queues any reply
    task automatic parse_word(input xpm_word_t w);
        pen_reply_t          r;
        logic [ID_W-1:0]     mask;
        logic [4:0]          nib;
        logic [COLOUR_W-1:0] colour;
        bit                  hit;
        r = '0;
        if (w.op == OP_LOOKUP) begin
            mask = id_mask_now();
            hit = 1'b0;
            r.kind = KIND_LOOKUP;
            for (int k = 0; k < pens_in_use(); k++) begin
                if (!hit && ((pen_ids[k] & mask) == (w.pixel_id & mask))) begin
                    hit = 1'b1;
                    r.index = k[7:0];
                    r.colour = pen_colours[k];
                    r.found = 1'b1;
                end
            end
            reply_q.push_back(r);
            return;
        end
        if (is_space(w.ch)) begin
            if (id_got != 0 && line_phase != PH_LAST) line_phase = line_phase + 3'd1;
        end else if (line_phase == PH_ID) begin
            if (id_got < id_chars_now()) begin
                id_word[id_got*8 +: 8] = w.ch;
                id_got++;
            end
        end else if (line_phase == PH_HASH) begin
            if (w.ch == CH_HASH) line_phase = PH_HEX;
        end else if (line_phase == PH_HEX) begin
            nib = hex_nibble(w.ch);
            if (nib[4]) begin
                bad_hex_seen = 1'b1;
            end else begin
                hex_sum = {hex_sum[COLOUR_W-5:0], nib[3:0]};
                if (hex_digits < HEX_FULL) hex_digits++;
            end
        end
        if (!w.line_end) return;
        // short hex strings are left-aligned
        if (hex_digits == 0) colour = '0;
        else if (hex_digits >= HEX_FULL) colour = hex_sum;
        else colour = hex_sum << ((8 - hex_digits) * 4);
        r.kind = KIND_ENTRY;
        r.error = bad_hex_seen || (pen_next >= pens_in_use());
        if (!r.error) begin
            pen_ids[pen_next] = id_word;
            pen_colours[pen_next] = colour;
            r.index = pen_next[7:0];
            r.colour = colour;
            r.found = 1'b1;
            pen_next++;
        end
        reply_q.push_back(r);
        line_phase = PH_ID;
        id_got = 0;
        id_word = '0;
        hex_sum = '0;
        hex_digits = '0;
    endtask

    task automatic push_word(input xpm_word_t w);
        word_q.push_back(w);
        words_queued++;
        parse_word(w);
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        xpm_word_t w;
        w.op = OP_CHAR;
        w.ch = c;
        w.line_end = last;
        w.pixel_id = rand_id();
        push_word(w);
    endtask

    task automatic send_lookup(input logic [ID_W-1:0] id);
        xpm_word_t w;
        w.op = OP_LOOKUP;
        w.ch = 8'($urandom);
        w.line_end = 1'($urandom);
        w.pixel_id = id;
        push_word(w);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_space();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] rand_hex_char();
        string hx;
        hx = "0123456789abcdefABCDEF";
        return hx[$urandom_range(0, 21)];
    endfunction

    function automatic logic [7:0] rand_id_char();
        string few;
        logic [7:0] c;
        few = "ab";
        // a narrow alphabet half the time so that ids repeat
        if ($urandom_range(0, 1) == 0) return few[$urandom_range(0, 1)];
        do c = 8'($urandom); while (is_space(c));
        return c;
    endfunction

    task automatic random_line(input int short_pct);
        logic [7:0] text[$];
        logic [7:0] c;
        logic [4:0] nib;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < short_pct) begin
            repeat ($urandom_range(1, 3)) text.push_back(rand_id_char());
        end else if (pick < short_pct + (100 - short_pct) * 3 / 4) begin
            repeat ($urandom_range(0, 2)) text.push_back(rand_space());
            repeat ($urandom_range(1, 6)) text.push_back(rand_id_char());
            text.push_back(rand_space());
            text.push_back(rand_id_char());
            text.push_back(rand_space());
            text.push_back(CH_HASH);
            repeat ($urandom_range(0, 10)) text.push_back(rand_hex_char());
            if ($urandom_range(0, 3) == 0) begin
                text.push_back(rand_space());
                repeat (2) text.push_back(rand_id_char());
            end
        end else begin
            repeat ($urandom_range(1, 16)) begin
                case ($urandom_range(0, 3))
                    0: text.push_back(rand_space());
                    1: text.push_back(CH_HASH);
                    2: text.push_back(rand_hex_char());
                    default: text.push_back(8'($urandom));
                endcase
            end
        end
        for (int i = 0; i < text.size(); i++) begin
            c = text[i];
            nib = hex_nibble(c);
            // keep the table alive: no garbage hex until the sticky error is wanted
            if (line_phase == PH_HEX && !bad_hex_seen && !is_space(c) && nib[4]) begin
                c = rand_hex_char();
            end
            send_char(c, i == text.size() - 1);
        end
    endtask

    task automatic random_lookup();
        logic [ID_W-1:0] mask;
        logic [ID_W-1:0] id;
        int              k;
        mask = id_mask_now();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                if (pen_next == 0) begin
                    id = rand_id();
                end else begin
                    k = $urandom_range(0, pen_next - 1);
                    id = (pen_ids[k] & mask) | (rand_id() & ~mask);
                end
            end
            6: id = '0;
            7: id = '1;
            default: id = rand_id();
        endcase
        send_lookup(id);
    endtask

    task automatic run_mix(input int n, input int short_pct);
        int stop;
        stop = words_queued + n;
        while (words_queued < stop) begin
            // only look up once every entry in use has been written
            if (pens_in_use() <= pen_next && $urandom_range(0, 3) == 0) random_lookup();
            else random_line(short_pct);
        end
    endtask

    task automatic wait_idle();
        do @(negedge aclk); while (words_taken != words_queued || reply_q.size() != 0);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [CFG_W-1:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= r;
        cfg_wdata <= v;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (r == REG_CHARS_PER_COLOUR) reg_cpc = v[CPC_W-1:0];
        else reg_cc = v;
    endtask

    // input driver
    always @(negedge aclk) begin : feed_words
        xpm_word_t cur;
        if (aresetn && (!s_tvalid || s_took)) begin
            if (s_gap != 0) begin
                s_gap--;
                s_tvalid <= 1'b0;
            end else if (word_q.size() != 0) begin
                cur = word_q.pop_front();
                s_tdata  <= {cur.pixel_id, cur.ch};
                s_tuser  <= cur.op;
                s_tlast  <= cur.line_end;
                s_tvalid <= 1'b1;
                if ($urandom_range(0, 39) == 0) s_burst = !s_burst;
                s_gap = draw_wait(s_burst);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result back-pressure
    always @(negedge aclk) begin : pace_replies
        if (m_took) begin
            if ($urandom_range(0, 39) == 0) m_burst = !m_burst;
            m_wait = draw_wait(m_burst);
        end else if (m_wait != 0) begin
            m_wait--;
        end
        m_tready <= (m_wait == 0);
    end

    always @(posedge aclk) begin : check_replies
        pen_reply_t got;
        pen_reply_t want;
        s_took <= s_tvalid && s_tready;
        m_took <= m_tvalid && m_tready;
        if (s_tvalid && s_tready) words_taken <= words_taken + 1;
        if (aresetn && m_tvalid && m_tready) begin
            got.kind   = m_tuser[0];
            got.index  = m_tdata[7:0];
            got.colour = m_tdata[39:8];
            got.found  = m_tdata[40];
            got.error  = m_tdata[41];
            if (reply_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got kind=%0d index=%0d",
                         $realtime, got.kind, got.index,
                         " colour=%08h found=%0d error=%0d",
                         got.colour, got.found, got.error);
                fail_count++;
            end else begin
                want = reply_q.pop_front();
                if (got.kind !== want.kind || got.index !== want.index ||
                    got.colour !== want.colour || got.found !== want.found ||
                    got.error !== want.error) begin
                    $display("%0t: mismatch, expected kind=%0d index=%0d colour=%08h",
                             $realtime, want.kind, want.index, want.colour,
                             " found=%0d error=%0d, got kind=%0d index=%0d",
                             want.found, want.error, got.kind, got.index,
                             " colour=%08h found=%0d error=%0d",
                             got.colour, got.found, got.error);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: one-character ids, two entries
        send_text(" b c #F");
        send_text("zy\tm #");
        send_lookup({32'h0, "z"});
        send_lookup({32'hFFFF_FFFF, "b"});
        send_lookup('0);
        send_char(8'hFF, 1'b1);

        // zero id length and an empty table
        write_reg(REG_CHARS_PER_COLOUR, 9'd0);
        write_reg(REG_COLOUR_COUNT, 9'd0);
        send_char(8'h00, 1'b1);
        send_lookup('1);

        write_reg(REG_CHARS_PER_COLOUR, 9'd5);
        write_reg(REG_COLOUR_COUNT, 9'd24);
        run_mix(300, 30);

        // oversized settings, then fill the whole table with mostly short lines
        write_reg(REG_CHARS_PER_COLOUR, 9'd7);
        write_reg(REG_COLOUR_COUNT, 9'd511);
        while (pen_next < MAX_PENS) random_line(90);

        write_reg(REG_CHARS_PER_COLOUR, 9'd3);
        write_reg(REG_COLOUR_COUNT, 9'd256);
        run_mix(60, 30);

        // garbage hex poisons this and every later line
        write_reg(REG_CHARS_PER_COLOUR, 9'd2);
        write_reg(REG_COLOUR_COUNT, 9'd1);
        send_text("k c #12G4");
        send_text("m c #00");
        run_mix(40, 30);

        wait_idle();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/xpmct_pkg.sv
rtl/xpmct_ram.sv
rtl/xpmct_parse.sv
rtl/xpmct_scan.sv
rtl/xpm_colour_table_decoder_top.sv
dv/tb_xpm_colour_table_decoder_top.sv
